@@ rtl/core/rptm_pkg.sv @@
// ----------------------------------------------------------------------------
// rptm_pkg
// Types and constants shared by the radix page table mapper.
// ----------------------------------------------------------------------------
package rptm_pkg;

	// Fixed geometry of one table page
	localparam int IDX_W   = 9;
	localparam int PFN_W   = 40;
	localparam int PADDR_W = 52;
	localparam int ENTRY_W = 64;
	localparam int FLAGS_W = 12;

	// Entry bits
	localparam int ENT_PRESENT = 0;
	localparam int ENT_WRITE   = 1;
	localparam int ENT_LARGE   = 7;

	// Commands
	localparam logic CMD_MAP_2M = 1'b0;
	localparam logic CMD_MAP_4K = 1'b1;

	// Walk levels
	localparam logic [1:0] LVL_PML4 = 2'd3;
	localparam logic [1:0] LVL_PDPT = 2'd2;
	localparam logic [1:0] LVL_PD   = 2'd1;
	localparam logic [1:0] LVL_PT   = 2'd0;

	// Result status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_FULL     = 2'd1;
	localparam logic [1:0] STAT_CONFLICT = 2'd2;

	typedef struct packed {
		logic                 command;
		logic [47:0]          virt_addr;
		logic [PADDR_W-1:0]   phys_addr;
		logic [FLAGS_W-1:0]   page_flags;
	} req_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [4:0] tables_in_use;
	} rsp_item_t;

	typedef enum logic [2:0] {
		SEQ_CLEAR,
		SEQ_IDLE,
		SEQ_READ,
		SEQ_EVAL,
		SEQ_LEAF,
		SEQ_DONE
	} seq_state_t;

endpackage

@@ rtl/core/radix_page_table_mapper.sv @@
// ----------------------------------------------------------------------------
// radix_page_table_mapper
// Walk: each level is read, then evaluated (step or allocate); the leaf
// is written at PD for 2MB, at PT for 4KB; early stop on full or conflict.
// Requests: one at a time; the next transfer is taken once the result is registered.
// Reset: the whole pool is cleared in SEQ_CLEAR while requests are stalled.
// ----------------------------------------------------------------------------
module radix_page_table_mapper #(
	parameter int TABLE_PAGES = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [rptm_pkg::PADDR_W-1:0] cfg_wr_data,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  rptm_pkg::req_item_t         req,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output rptm_pkg::rsp_item_t         rsp
);
	import rptm_pkg::*;

	localparam int TW    = $clog2(TABLE_PAGES);
	localparam int CW    = $clog2(TABLE_PAGES + 1);
	localparam int AW    = TW + IDX_W;
	localparam int DEPTH = TABLE_PAGES * (2 ** IDX_W);

	seq_state_t         state_q, state_nxt;
	logic [PADDR_W-1:0] base_q;
	req_item_t          req_q;
	logic [1:0]         level_q;
	logic [TW-1:0]      table_q;
	logic [CW-1:0]      next_free_q;
	logic [AW-1:0]      clr_q;
	logic [1:0]         status_q;
	logic               rsp_valid_q;
	rsp_item_t          rsp_q;

	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [ENTRY_W-1:0] mem_wdata;
	logic [AW-1:0]      mem_raddr;
	logic [ENTRY_W-1:0] entry;

	logic [IDX_W-1:0]   idx_cur;
	logic               present, big_leaf, leaf_conflict, pool_full, out_of_pool;
	logic [PFN_W-1:0]   au_a, au_b, au_sum;
	logic [1:0]         eval_status;
	logic [TW-1:0]      child;
	logic [1:0]         level_nxt;
	logic               go_leaf, clr_done, rsp_free;

	// Table pool and shared adder
	rptm_table_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.rd_addr (mem_raddr),
		.rd_data (entry)
	);

	rptm_addr_unit u_addr (
		.a   (au_a),
		.b   (au_b),
		.sub (present),
		.sum (au_sum)
	);

	// Index of the current level
	always_comb begin
		unique case (level_q)
			LVL_PML4: idx_cur = req_q.virt_addr[47:39];
			LVL_PDPT: idx_cur = req_q.virt_addr[38:30];
			LVL_PD:   idx_cur = req_q.virt_addr[29:21];
			default:  idx_cur = req_q.virt_addr[20:12];
		endcase
	end

	// Entry decode and walk step
	always_comb begin
		present       = entry[ENT_PRESENT];
		big_leaf      = entry[ENT_LARGE];
		leaf_conflict = (level_q == LVL_PD) && (req_q.command == CMD_MAP_4K)
			&& present && big_leaf;
		pool_full     = next_free_q >= CW'(TABLE_PAGES);
		au_a          = present ? entry[PADDR_W-1:12] : base_q[PADDR_W-1:12];
		au_b          = present ? base_q[PADDR_W-1:12] : PFN_W'(next_free_q);
		out_of_pool   = au_sum >= PFN_W'(TABLE_PAGES);
		priority if (leaf_conflict) begin
			eval_status = STAT_CONFLICT;
		end else if (present) begin
			eval_status = out_of_pool ? STAT_CONFLICT : STAT_OK;
		end else begin
			eval_status = pool_full ? STAT_FULL : STAT_OK;
		end
		child     = present ? au_sum[TW-1:0] : next_free_q[TW-1:0];
		level_nxt = level_q - 2'd1;
		go_leaf   = (level_nxt == LVL_PT)
			|| ((level_nxt == LVL_PD) && (req_q.command == CMD_MAP_2M));
		clr_done  = clr_q == AW'(DEPTH - 1);
		rsp_free  = !rsp_valid_q || !rsp_stall;
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			SEQ_CLEAR: if (clr_done) state_nxt = SEQ_IDLE;
			SEQ_IDLE:  if (req_valid) state_nxt = SEQ_READ;
			SEQ_READ:  state_nxt = SEQ_EVAL;
			SEQ_EVAL: begin
				if (eval_status != STAT_OK) begin
					state_nxt = SEQ_DONE;
				end else begin
					state_nxt = go_leaf ? SEQ_LEAF : SEQ_READ;
				end
			end
			SEQ_LEAF:  state_nxt = SEQ_DONE;
			SEQ_DONE:  if (rsp_free) state_nxt = SEQ_IDLE;
			default:   state_nxt = SEQ_IDLE;
		endcase
	end

	// Outputs of the sequencer: memory port and request stall
	always_comb begin
		req_stall = state_q != SEQ_IDLE;
		mem_raddr = {table_q, idx_cur};
		mem_we    = 1'b0;
		mem_waddr = {table_q, idx_cur};
		mem_wdata = '0;
		unique case (state_q)
			SEQ_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			SEQ_EVAL: begin
				// new table pointer: present plus writable
				mem_we = !present && !pool_full;
				mem_wdata = {12'b0, au_sum, 12'b0};
				mem_wdata[ENT_PRESENT] = 1'b1;
				mem_wdata[ENT_WRITE]   = 1'b1;
			end
			SEQ_LEAF: begin
				mem_we    = 1'b1;
				mem_wdata = {12'b0, req_q.phys_addr}
					| {{(ENTRY_W-FLAGS_W){1'b0}}, req_q.page_flags};
				if (level_q == LVL_PD) begin
					mem_wdata[ENT_LARGE] = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_wr_en) begin
			base_q <= cfg_wr_data;
		end
	end

	// Sequencer state, walk position and allocator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SEQ_CLEAR;
			clr_q       <= '0;
			level_q     <= LVL_PML4;
			table_q     <= '0;
			next_free_q <= CW'(1);
			status_q    <= STAT_OK;
		end else begin
			state_q <= state_nxt;
			unique case (state_q)
				SEQ_CLEAR: clr_q <= clr_q + AW'(1);
				SEQ_IDLE: begin
					level_q <= LVL_PML4;
					table_q <= '0;
				end
				SEQ_EVAL: begin
					status_q <= eval_status;
					if (eval_status == STAT_OK) begin
						table_q <= child;
						level_q <= level_nxt;
						if (!present) begin
							next_free_q <= next_free_q + CW'(1);
						end
					end
				end
				SEQ_LEAF: status_q <= STAT_OK;
				default: ;
			endcase
		end
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (state_q == SEQ_IDLE && req_valid) begin
			req_q <= req;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == SEQ_DONE && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == SEQ_DONE && rsp_free) begin
			rsp_q.status        <= status_q;
			rsp_q.tables_in_use <= 5'(next_free_q);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Checks
	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == SEQ_DONE))
		else $error("result raised outside completion");

	a_alloc_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(next_free_q >= CW'(1)) && (next_free_q <= CW'(TABLE_PAGES)))
		else $error("allocator count out of range");

	a_alloc_in_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(next_free_q != $past(next_free_q)) |-> $past(state_q == SEQ_EVAL))
		else $error("allocator moved outside a walk step");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SEQ_IDLE || state_q == SEQ_DONE) |-> !mem_we)
		else $error("table write while no walk is active");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (state_q == SEQ_READ && level_q == LVL_PML4))
		else $error("transfer did not start a walk at the root");

endmodule

@@ rtl/core/rptm_table_mem.sv @@
// ----------------------------------------------------------------------------
// rptm_table_mem
// Table pool storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rptm_table_mem #(
	parameter int DEPTH = 8192,
	parameter int AW    = 13
) (
	input  logic                         clk,
	input  logic                         wr_en,
	input  logic [AW-1:0]                wr_addr,
	input  logic [rptm_pkg::ENTRY_W-1:0] wr_data,
	input  logic [AW-1:0]                rd_addr,
	output logic [rptm_pkg::ENTRY_W-1:0] rd_data
);
	import rptm_pkg::*;

	logic [ENTRY_W-1:0] mem_q [DEPTH];
	logic [ENTRY_W-1:0] rd_data_q;

	// Write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

@@ rtl/core/rptm_addr_unit.sv @@
// ----------------------------------------------------------------------------
// rptm_addr_unit
// Shared page-frame adder: pointer minus pool base, or pool base plus table.
// ----------------------------------------------------------------------------
module rptm_addr_unit (
	input  logic [rptm_pkg::PFN_W-1:0] a,
	input  logic [rptm_pkg::PFN_W-1:0] b,
	input  logic                       sub,
	output logic [rptm_pkg::PFN_W-1:0] sum
);
	import rptm_pkg::*;

	logic [PFN_W-1:0] b_eff;

	// Two's complement subtract when sub is set; wraps modulo 2^40
	always_comb begin
		b_eff = sub ? ~b : b;
		sum   = a + b_eff + PFN_W'(sub);
	end

endmodule
